/* rtl/cpg_pkg.sv */
package cpg_pkg;

    localparam int CPG_PHASE_BITS = 16;
    localparam int CPG_QUEUE_DEPTH = 4;
    localparam int CPG_CFG_INDEX_BITS = 3;
    localparam int CPG_CFG_DATA_BITS = 32;

    localparam logic [CPG_CFG_INDEX_BITS-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CPG_CFG_INDEX_BITS-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CPG_CFG_INDEX_BITS-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CPG_CFG_INDEX_BITS-1:0] CFG_REF_X = 3'd3;
    localparam logic [CPG_CFG_INDEX_BITS-1:0] CFG_REF_Y = 3'd4;
    localparam logic [CPG_CFG_INDEX_BITS-1:0] CFG_REF_Z = 3'd5;
    localparam logic [CPG_CFG_INDEX_BITS-1:0] CFG_RADIUS = 3'd6;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] UNIT_ONE = 31'h4000_0000;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [29:0] x;
        logic [1:0]  quad;
        logic        fold;
    } cpg_angle_t;

    typedef struct packed {
        logic [2:0][31:0] center;
        logic [30:0]      radius;
        logic [2:0][31:0] u;
        logic [2:0][31:0] v;
        logic             ok;
    } cpg_basis_t;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_START,
        BS_ABS,
        BS_NORM,
        BS_SQ,
        BS_SQRT,
        BS_DIVLD,
        BS_DIV,
        BS_STORE,
        BS_CROSS
    } bs_state_t;

    function automatic logic signed [63:0] round_q30(input logic signed [63:0] val);
        logic [63:0] mag;
        logic [63:0] rnd;
        mag = val[63] ? (64'd0 - val) : val;
        rnd = (mag + 64'h2000_0000) >> 30;
        return val[63] ? $signed(64'd0 - rnd) : $signed(rnd);
    endfunction

endpackage

/* rtl/cpg_queue.sv */
module cpg_queue
    import cpg_pkg::*;
#(
    parameter int DEPTH = CPG_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cpg_angle_t push_data,
    input  logic       pop,
    output cpg_angle_t head,
    output logic       full,
    output logic       empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cpg_angle_t           mem_reg [DEPTH];
    logic [PW-1:0]        wr_reg;
    logic [PW-1:0]        wr_next;
    logic [PW-1:0]        rd_reg;
    logic [PW-1:0]        rd_next;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_next;

    assign full = (cnt_reg == ($clog2(DEPTH+1))'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head = mem_reg[rd_reg];

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

/* rtl/cpg_front.sv */
module cpg_front
    import cpg_pkg::*;
#(
    parameter int PHASE_BITS = CPG_PHASE_BITS
)
(
    input  logic                  phase_valid,
    output logic                  phase_stall,
    input  logic [PHASE_BITS-1:0] phase,
    input  logic                  basis_busy,
    input  logic                  queue_full,
    output logic                  push,
    output cpg_angle_t            push_data
);

    logic [31:0] turn;
    logic [29:0] rem;
    logic [29:0] folded;
    logic        fold;
    logic [60:0] scaled;

    assign phase_stall = basis_busy || queue_full;
    assign push = phase_valid && !phase_stall;

    // The phase is taken to 2^32 per turn, folded into the first eighth turn
    // of its quadrant and turned into Q0.30 radians.
    assign turn = {phase, (32 - PHASE_BITS)'(0)};
    assign rem = turn[29:0];
    assign fold = (rem > 30'h2000_0000);
    assign folded = fold ? (30'h0 - rem) : rem;
    assign scaled = 61'(folded) * 61'(HALF_PI_Q30) + 61'h2000_0000;

    assign push_data.x = scaled[59:30];
    assign push_data.quad = turn[31:30];
    assign push_data.fold = fold;

endmodule

/* rtl/cpg_basis.sv */
module cpg_basis
    import cpg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CPG_CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CPG_CFG_DATA_BITS-1:0]  cfg_data,
    output logic                          busy,
    output cpg_basis_t                    basis
);

    logic [2:0][31:0] center_reg;
    logic [2:0][31:0] ref_reg;
    logic [30:0]      radius_reg;

    bs_state_t        state_reg;
    bs_state_t        state_next;
    logic [1:0]       pass_reg;
    logic [1:0]       pass_next;
    logic [5:0]       cnt_reg;
    logic [5:0]       cnt_next;
    logic [1:0]       ci_reg;
    logic [1:0]       ci_next;
    logic [2:0][63:0] vec_reg;
    logic [2:0][63:0] vec_next;
    logic [2:0][63:0] mag_reg;
    logic [2:0][63:0] mag_next;
    logic [2:0]       neg_reg;
    logic [2:0]       neg_next;
    logic [63:0]      mx_reg;
    logic [63:0]      mx_next;
    logic [63:0]      acc_reg;
    logic [63:0]      acc_next;
    logic [62:0]      res_reg;
    logic [62:0]      res_next;
    logic [62:0]      bit_reg;
    logic [62:0]      bit_next;
    logic [60:0]      num_reg;
    logic [60:0]      num_next;
    logic [30:0]      rem_reg;
    logic [30:0]      rem_next;
    logic [30:0]      quo_reg;
    logic [30:0]      quo_next;
    logic [2:0][31:0] nvec_reg;
    logic [2:0][31:0] nvec_next;
    logic [2:0][31:0] p_reg;
    logic [2:0][31:0] p_next;
    logic [2:0][31:0] u_reg;
    logic [2:0][31:0] u_next;
    logic [2:0][31:0] v_reg;
    logic [2:0][31:0] v_next;
    logic             ok_reg;
    logic             ok_next;

    logic [63:0]      sq_term;
    logic [63:0]      root_try;
    logic [31:0]      rem_try;
    logic [31:0]      op_a;
    logic [31:0]      op_b;
    logic [2:0][31:0] cross_a;
    logic signed [63:0] prod;
    logic [30:0]      len;

    assign busy = (state_reg != BS_IDLE);
    assign len = res_reg[30:0];

    assign basis.center = center_reg;
    assign basis.radius = radius_reg;
    assign basis.u = u_reg;
    assign basis.v = v_reg;
    assign basis.ok = ok_reg;

    assign cross_a = (pass_reg == 2'd1) ? center_reg : u_reg;
    assign sq_term = 64'(mag_reg[cnt_reg[1:0]][29:0]) * 64'(mag_reg[cnt_reg[1:0]][29:0]);
    assign root_try = 64'(res_reg) + 64'(bit_reg);
    assign rem_try = {rem_reg, num_reg[60]};
    assign prod = $signed(op_a) * $signed(op_b);

    always_comb
    begin
        unique case (cnt_reg[2:0])
            3'd0:    begin op_a = cross_a[1]; op_b = p_reg[2]; end
            3'd1:    begin op_a = cross_a[2]; op_b = p_reg[1]; end
            3'd2:    begin op_a = cross_a[2]; op_b = p_reg[0]; end
            3'd3:    begin op_a = cross_a[0]; op_b = p_reg[2]; end
            3'd4:    begin op_a = cross_a[0]; op_b = p_reg[1]; end
            3'd5:    begin op_a = cross_a[1]; op_b = p_reg[0]; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next = pass_reg;
        cnt_next = cnt_reg;
        ci_next = ci_reg;
        vec_next = vec_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        mx_next = mx_reg;
        acc_next = acc_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        nvec_next = nvec_reg;
        p_next = p_reg;
        u_next = u_reg;
        v_next = v_reg;
        ok_next = ok_reg;

        unique case (state_reg)
            BS_IDLE:
            begin
            end
            BS_START:
            begin
                ok_next = 1'b0;
                pass_next = 2'd0;
                for (int i = 0; i < 3; i++)
                begin
                    vec_next[i] = {{32{ref_reg[i][31]}}, ref_reg[i]};
                end
                state_next = BS_ABS;
            end
            BS_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_next[i] = vec_reg[i][63];
                    mag_next[i] = vec_reg[i][63] ? (64'd0 - vec_reg[i]) : vec_reg[i];
                end
                mx_next = mag_next[0];
                if (mag_next[1] > mx_next)
                begin
                    mx_next = mag_next[1];
                end
                if (mag_next[2] > mx_next)
                begin
                    mx_next = mag_next[2];
                end
                state_next = BS_NORM;
            end
            BS_NORM:
            begin
                if (mx_reg == '0)
                begin
                    ok_next = 1'b0;
                    state_next = BS_IDLE;
                end
                else if (mx_reg[63:30] != '0)
                begin
                    mx_next = mx_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else if (!mx_reg[29])
                begin
                    mx_next = mx_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end
                else
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    state_next = BS_SQ;
                end
            end
            BS_SQ:
            begin
                acc_next = acc_reg + sq_term;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd2)
                begin
                    res_next = '0;
                    bit_next = 63'h4000_0000_0000_0000;
                    state_next = BS_SQRT;
                end
            end
            BS_SQRT:
            begin
                if (acc_reg >= root_try)
                begin
                    acc_next = acc_reg - root_try;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == 63'd1)
                begin
                    ci_next = '0;
                    state_next = BS_DIVLD;
                end
            end
            BS_DIVLD:
            begin
                num_next = {mag_reg[ci_reg][30:0], 30'd0} + 61'(len >> 1);
                rem_next = '0;
                quo_next = '0;
                cnt_next = '0;
                state_next = BS_DIV;
            end
            BS_DIV:
            begin
                num_next = num_reg << 1;
                if (rem_try >= {1'b0, len})
                begin
                    rem_next = 31'(rem_try - {1'b0, len});
                    quo_next = {quo_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_try[30:0];
                    quo_next = {quo_reg[29:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd60)
                begin
                    nvec_next[ci_reg] = neg_reg[ci_reg] ? (32'd0 - {1'b0, quo_next})
                                                        : {1'b0, quo_next};
                    if (ci_reg == 2'd2)
                    begin
                        state_next = BS_STORE;
                    end
                    else
                    begin
                        ci_next = ci_reg + 1'b1;
                        state_next = BS_DIVLD;
                    end
                end
            end
            BS_STORE:
            begin
                cnt_next = '0;
                unique case (pass_reg)
                    2'd0:
                    begin
                        p_next = nvec_reg;
                        pass_next = 2'd1;
                        state_next = BS_CROSS;
                    end
                    2'd1:
                    begin
                        u_next = nvec_reg;
                        pass_next = 2'd2;
                        state_next = BS_CROSS;
                    end
                    default:
                    begin
                        v_next = nvec_reg;
                        ok_next = 1'b1;
                        state_next = BS_IDLE;
                    end
                endcase
            end
            BS_CROSS:
            begin
                if (!cnt_reg[0])
                begin
                    vec_next[cnt_reg[2:1]] = prod;
                end
                else
                begin
                    vec_next[cnt_reg[2:1]] = vec_reg[cnt_reg[2:1]] - prod;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd5)
                begin
                    state_next = BS_ABS;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            state_next = BS_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_START;
            ok_reg <= 1'b0;
            center_reg <= '0;
            ref_reg <= '0;
            radius_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg <= ok_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CENTER_X: center_reg[0] <= cfg_data;
                    CFG_CENTER_Y: center_reg[1] <= cfg_data;
                    CFG_CENTER_Z: center_reg[2] <= cfg_data;
                    CFG_REF_X:    ref_reg[0] <= cfg_data;
                    CFG_REF_Y:    ref_reg[1] <= cfg_data;
                    CFG_REF_Z:    ref_reg[2] <= cfg_data;
                    CFG_RADIUS:   radius_reg <= cfg_data[30:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg <= pass_next;
        cnt_reg <= cnt_next;
        ci_reg <= ci_next;
        vec_reg <= vec_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        mx_reg <= mx_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        nvec_reg <= nvec_next;
        p_reg <= p_next;
        u_reg <= u_next;
        v_reg <= v_next;
    end

endmodule

/* rtl/cpg_back.sv */
module cpg_back
    import cpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cpg_angle_t  head,
    input  logic        empty,
    output logic        pop,
    input  cpg_basis_t  basis,
    output logic        point_valid,
    input  logic        point_stall,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic        degenerate
);

    localparam int NT = 14;

    logic adv;

    logic [29:0]        ta_reg [0:NT];
    logic [30:0]        tb_reg [0:NT];
    logic [29:0]        x2_reg [0:NT];
    logic signed [32:0] ss_reg [0:NT];
    logic signed [32:0] cs_reg [0:NT];
    logic [1:0]         quad_reg [0:NT];
    logic               fold_reg [0:NT];
    logic [NT:0]        vld_reg;

    logic [59:0]        sq0;
    logic [29:0]        x2_0;

    logic [30:0]        sr;
    logic [30:0]        cr;
    logic [30:0]        s0;
    logic [30:0]        c0;
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_next;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic               vt_reg;

    logic signed [63:0] pu_reg [3];
    logic signed [63:0] pv_reg [3];
    logic               vp_reg;
    logic signed [32:0] w_reg [3];
    logic               vw_reg;
    logic signed [63:0] rw_reg [3];
    logic               vr_reg;

    logic signed [63:0] sum [3];
    logic [31:0]        res [3];

    assign adv = !point_valid || !point_stall;
    assign pop = adv && !empty;

    assign sq0 = 60'(head.x) * 60'(head.x) + 60'h2000_0000;
    assign x2_0 = sq0[59:30];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ta_reg[0] <= head.x;
            tb_reg[0] <= UNIT_ONE;
            x2_reg[0] <= x2_0;
            ss_reg[0] <= $signed({3'b0, head.x});
            cs_reg[0] <= $signed({2'b0, UNIT_ONE});
            quad_reg[0] <= head.quad;
            fold_reg[0] <= head.fold;
        end
    end

    // Taylor series: an odd stage multiplies each term by x^2, an even
    // stage divides it by the factorial step and adds it to or subtracts it from the sum, alternating.
    for (genvar j = 1; j <= NT; j++)
    begin : g_tay
        localparam int K = (j + 1) / 2;
        localparam logic [63:0] DS = 64'((2 * K) * (2 * K + 1));
        localparam logic [63:0] DC = 64'((2 * K - 1) * (2 * K));
        localparam int KS = 30 + $clog2((2 * K) * (2 * K + 1));
        localparam int KC = 30 + $clog2((2 * K - 1) * (2 * K));
        localparam logic [63:0] MS = ((64'd1 << KS) + DS - 64'd1) / DS;
        localparam logic [63:0] MC = ((64'd1 << KC) + DC - 64'd1) / DC;

        if (j % 2 == 1)
        begin : g_mul
            logic [60:0] pa;
            logic [60:0] pb;
            assign pa = 61'(ta_reg[j-1]) * 61'(x2_reg[j-1]) + 61'h2000_0000;
            assign pb = 61'(tb_reg[j-1]) * 61'(x2_reg[j-1]) + 61'h2000_0000;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ta_reg[j] <= pa[59:30];
                    tb_reg[j] <= {1'b0, pb[59:30]};
                    ss_reg[j] <= ss_reg[j-1];
                    cs_reg[j] <= cs_reg[j-1];
                end
            end
        end
        else
        begin : g_div
            logic [61:0] qa;
            logic [61:0] qb;
            logic [29:0] da;
            logic [29:0] db;
            assign qa = 62'(ta_reg[j-1]) * 62'(MS[31:0]);
            assign qb = 62'(tb_reg[j-1]) * 62'(MC[31:0]);
            assign da = 30'(qa >> KS);
            assign db = 30'(qb >> KC);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ta_reg[j] <= da;
                    tb_reg[j] <= {1'b0, db};
                    if (K % 2 == 1)
                    begin
                        ss_reg[j] <= ss_reg[j-1] - $signed({3'b0, da});
                        cs_reg[j] <= cs_reg[j-1] - $signed({3'b0, db});
                    end
                    else
                    begin
                        ss_reg[j] <= ss_reg[j-1] + $signed({3'b0, da});
                        cs_reg[j] <= cs_reg[j-1] + $signed({3'b0, db});
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x2_reg[j] <= x2_reg[j-1];
                quad_reg[j] <= quad_reg[j-1];
                fold_reg[j] <= fold_reg[j-1];
            end
        end
    end

    always_comb
    begin
        if (ss_reg[NT] < 0)
        begin
            sr = '0;
        end
        else if (ss_reg[NT] > $signed({2'b0, UNIT_ONE}))
        begin
            sr = UNIT_ONE;
        end
        else
        begin
            sr = ss_reg[NT][30:0];
        end
        if (cs_reg[NT] < 0)
        begin
            cr = '0;
        end
        else if (cs_reg[NT] > $signed({2'b0, UNIT_ONE}))
        begin
            cr = UNIT_ONE;
        end
        else
        begin
            cr = cs_reg[NT][30:0];
        end
        s0 = fold_reg[NT] ? cr : sr;
        c0 = fold_reg[NT] ? sr : cr;
        case (quad_reg[NT])
            QUAD_0:
            begin
                cos_next = $signed({1'b0, c0});
                sin_next = $signed({1'b0, s0});
            end
            QUAD_1:
            begin
                cos_next = -$signed({1'b0, s0});
                sin_next = $signed({1'b0, c0});
            end
            QUAD_2:
            begin
                cos_next = -$signed({1'b0, c0});
                sin_next = -$signed({1'b0, s0});
            end
            default:
            begin
                cos_next = $signed({1'b0, s0});
                sin_next = -$signed({1'b0, c0});
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = 64'($signed(basis.center[i])) + round_q30(rw_reg[i]);
            if (!basis.ok)
            begin
                res[i] = basis.center[i];
            end
            else if (sum[i] > 64'sd2147483647)
            begin
                res[i] = 32'h7FFF_FFFF;
            end
            else if (sum[i] < -64'sd2147483648)
            begin
                res[i] = 32'h8000_0000;
            end
            else
            begin
                res[i] = sum[i][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
            for (int i = 0; i < 3; i++)
            begin
                pu_reg[i] <= $signed(basis.u[i]) * cos_reg;
                pv_reg[i] <= $signed(basis.v[i]) * sin_reg;
                w_reg[i] <= 33'(round_q30(pu_reg[i] + pv_reg[i]));
                rw_reg[i] <= $signed({1'b0, basis.radius}) * w_reg[i];
            end
            if (vr_reg)
            begin
                out_x <= res[0];
                out_y <= res[1];
                out_z <= res[2];
                degenerate <= !basis.ok;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            vt_reg <= 1'b0;
            vp_reg <= 1'b0;
            vw_reg <= 1'b0;
            vr_reg <= 1'b0;
            point_valid <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NT-1:0], pop};
            vt_reg <= vld_reg[NT];
            vp_reg <= vt_reg;
            vw_reg <= vp_reg;
            vr_reg <= vw_reg;
            point_valid <= vr_reg;
        end
    end

endmodule

/* rtl/circle_point_generator_3d_core.sv */
// Channel   Direction  Handshake                  Payload
// phase     in         phase_valid / phase_stall  phase
// point     out        point_valid / point_stall  out_x, out_y, out_z, degenerate
// config    in         cfg_we                     cfg_index, cfg_data
//
// One point per cycle is sustained while the basis is idle and point_stall is
// low; a phase passes through the queue, the sin and cos series pipeline and
// the basis products to the output register. After reset and after every
// configuration write the basis sequencer runs, bound by its one-bit-a-cycle
// square root and divider, and phase_stall stays high meanwhile.
// A stalled output freezes the whole back pipeline; the four-entry phase queue
// keeps taking transfers until it fills.
module circle_point_generator_3d_core
    import cpg_pkg::*;
#(
    parameter int PHASE_BITS = CPG_PHASE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CPG_CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CPG_CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                          phase_valid,
    output logic                          phase_stall,
    input  logic [PHASE_BITS-1:0]         phase,
    output logic                          point_valid,
    input  logic                          point_stall,
    output logic [31:0]                   out_x,
    output logic [31:0]                   out_y,
    output logic [31:0]                   out_z,
    output logic                          degenerate
);

    logic       basis_busy;
    cpg_basis_t basis;
    logic       push;
    cpg_angle_t push_data;
    logic       pop;
    cpg_angle_t head;
    logic       full;
    logic       empty;

    cpg_basis u_basis (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (basis_busy),
        .basis     (basis)
    );

    cpg_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .phase_valid (phase_valid),
        .phase_stall (phase_stall),
        .phase       (phase),
        .basis_busy  (basis_busy),
        .queue_full  (full),
        .push        (push),
        .push_data   (push_data)
    );

    cpg_queue #(
        .DEPTH (CPG_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    cpg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .basis       (basis),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .degenerate  (degenerate)
    );

endmodule

/* rtl/cpg_checker.sv */
module cpg_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic        phase_valid,
    input logic        phase_stall,
    input logic        point_valid,
    input logic        point_stall,
    input logic [31:0] out_x,
    input logic [31:0] out_y,
    input logic [31:0] out_z,
    input logic        degenerate
);

    logic [7:0] pend_reg;
    logic [7:0] pend_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer = phase_valid && !phase_stall;
    assign out_xfer = point_valid && !point_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A configuration write restarts the basis computation, which holds off
    // new phases.
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> phase_stall)
        else $error("phase accepted right after a configuration write");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> (pend_reg != 8'd0))
        else $error("point offered with no phase outstanding");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> point_valid)
        else $error("point valid dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> $stable(out_x) && $stable(out_y)
            && $stable(out_z) && $stable(degenerate))
        else $error("point payload changed while stalled");

endmodule

bind circle_point_generator_3d_core cpg_checker u_cpg_checker (.*);

/* tb/circle_point_generator_3d_core_tb.sv */
`timescale 1ns / 1ps

module circle_point_generator_3d_core_tb;
    import cpg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        degen;
    } point_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [CPG_CFG_INDEX_BITS-1:0] cfg_index;
    logic [CPG_CFG_DATA_BITS-1:0]  cfg_data;
    logic                          phase_valid;
    logic                          phase_stall;
    logic [CPG_PHASE_BITS-1:0]     phase;
    logic                          point_valid;
    logic                          point_stall;
    logic [31:0]                   out_x;
    logic [31:0]                   out_y;
    logic [31:0]                   out_z;
    logic                          degenerate;

    logic [15:0] pending_phases[$];
    point_t      expected_points[$];
    logic signed [63:0] cur_center[3];
    logic signed [63:0] cur_ref[3];
    logic signed [63:0] cur_radius;
    int  errors;
    int  idle_cnt;
    int  stall_cnt;
    int  watchdog;
    bit  quiet;
    bit  in_xfer;

    circle_point_generator_3d_core u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .phase_valid(phase_valid), .phase_stall(phase_stall), .phase(phase),
        .point_valid(point_valid), .point_stall(point_stall),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .degenerate(degenerate)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [63:0] round_shift30(input logic signed [63:0] val);
        logic [63:0] mag;
        mag = val < 0 ? 64'd0 - val : val;
        mag = (mag + 64'h2000_0000) >> 30;
        return val < 0 ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] val);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > val) b = b >> 2;
        while (b != 0)
        begin
            if (val >= res + b)
            begin
                val = val - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit unit_vector(input logic signed [63:0] a[3],
                                       output logic signed [63:0] n[3]);
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] ssq;
        logic [63:0] len;
        logic [63:0] q;
        mx = 0;
        ssq = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = a[i] < 0 ? 64'd0 - a[i] : a[i];
            if (m[i] > mx) mx = m[i];
        end
        for (int i = 0; i < 3; i++) n[i] = 0;
        if (mx == 0) return 1'b0;
        while (mx >= (64'd1 << 30))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) ssq = ssq + m[i] * m[i];
        len = int_sqrt(ssq);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << 30) + (len >> 1)) / len;
            n[i] = a[i] < 0 ? -$signed(q) : $signed(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross_product(input logic signed [63:0] a[3],
                                          input logic signed [63:0] b[3],
                                          output logic signed [63:0] r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic void phase_to_sincos(input logic [15:0] ph,
                                            output logic signed [63:0] s,
                                            output logic signed [63:0] c);
        logic [63:0] a;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] k;
        logic signed [63:0] ss;
        logic signed [63:0] cs;
        logic signed [63:0] s0;
        logic signed [63:0] c0;
        logic [1:0] quad;
        bit fold;
        a = {48'd0, ph} << 16;
        quad = a[31:30];
        r = a & ((64'd1 << 30) - 1);
        fold = r > (64'd1 << 29);
        if (fold) r = (64'd1 << 30) - r;
        x = (r * HALF_PI_Q30 + (64'd1 << 29)) >> 30;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        ts = x;
        tc = UNIT_ONE;
        ss = x;
        cs = UNIT_ONE;
        for (k = 1; k <= 7; k++)
        begin
            ts = ((ts * x2 + (64'd1 << 29)) >> 30) / ((2 * k) * (2 * k + 1));
            tc = ((tc * x2 + (64'd1 << 29)) >> 30) / ((2 * k - 1) * (2 * k));
            if (k[0])
            begin
                ss = ss - $signed(ts);
                cs = cs - $signed(tc);
            end
            else
            begin
                ss = ss + $signed(ts);
                cs = cs + $signed(tc);
            end
        end
        if (ss < 0) ss = 0;
        if (ss > UNIT_ONE) ss = UNIT_ONE;
        if (cs < 0) cs = 0;
        if (cs > UNIT_ONE) cs = UNIT_ONE;
        s0 = fold ? cs : ss;
        c0 = fold ? ss : cs;
        case (quad)
            QUAD_0:  begin c = c0;  s = s0;  end
            QUAD_1:  begin c = -s0; s = c0;  end
            QUAD_2:  begin c = -c0; s = -s0; end
            default: begin c = s0;  s = -c0; end
        endcase
    endfunction

    function automatic point_t circle_point(input logic [15:0] ph);
        logic signed [63:0] p[3];
        logic signed [63:0] cu[3];
        logic signed [63:0] u[3];
        logic signed [63:0] cv[3];
        logic signed [63:0] v[3];
        logic signed [63:0] res[3];
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic signed [63:0] w;
        point_t pt;
        bit ok;
        ok = unit_vector(cur_ref, p);
        if (ok)
        begin
            cross_product(cur_center, p, cu);
            ok = unit_vector(cu, u);
        end
        if (ok)
        begin
            cross_product(u, p, cv);
            ok = unit_vector(cv, v);
        end
        phase_to_sincos(ph, s, c);
        for (int i = 0; i < 3; i++)
        begin
            res[i] = cur_center[i];
            if (ok)
            begin
                w = round_shift30(u[i] * c + v[i] * s);
                res[i] = cur_center[i] + round_shift30(cur_radius * w);
                if (res[i] > 64'sh7FFF_FFFF) res[i] = 64'sh7FFF_FFFF;
                if (res[i] < -64'sh8000_0000) res[i] = -64'sh8000_0000;
            end
        end
        pt.x = res[0][31:0];
        pt.y = res[1][31:0];
        pt.z = res[2][31:0];
        pt.degen = !ok;
        return pt;
    endfunction

    task automatic write_reg(input logic [CPG_CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < CFG_REF_X) cur_center[idx] = $signed(val);
        else if (idx < CFG_RADIUS) cur_ref[idx - CFG_REF_X] = $signed(val);
        else if (idx == CFG_RADIUS) cur_radius = {33'd0, val[30:0]};
    endtask

    task automatic set_circle(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz, input logic [31:0] rx,
                              input logic [31:0] ry, input logic [31:0] rz,
                              input logic [31:0] rad);
        wait (pending_phases.size() == 0 && !in_xfer && expected_points.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_REF_X, rx);
        write_reg(CFG_REF_Y, ry);
        write_reg(CFG_REF_Z, rz);
        write_reg(CFG_RADIUS, rad);
    endtask

    task automatic add_phase(input logic [15:0] ph);
        pending_phases = {pending_phases, ph};
    endtask

    task automatic queue_phases(input int n);
        for (int i = 0; i < n; i++)
            add_phase(16'($urandom));
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($signed($urandom_range(0, 20)) - 10) << 16;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_valid <= 1'b0;
            phase <= '0;
            idle_cnt <= 0;
            in_xfer <= 1'b0;
        end
        else
        begin
            if (phase_valid && !phase_stall)
            begin
                expected_points = {expected_points, circle_point(phase)};
            end
            if (!phase_valid || !phase_stall)
            begin
                if (idle_cnt > 0)
                begin
                    idle_cnt <= idle_cnt - 1;
                    phase_valid <= 1'b0;
                    in_xfer <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 5) == 0)
                begin
                    idle_cnt <= $urandom_range(0, 4);
                    phase_valid <= 1'b0;
                    in_xfer <= 1'b0;
                end
                else if (pending_phases.size() > 0)
                begin
                    phase <= pending_phases.pop_front();
                    phase_valid <= 1'b1;
                    in_xfer <= 1'b1;
                end
                else
                begin
                    phase_valid <= 1'b0;
                    in_xfer <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_stall <= 1'b0;
            stall_cnt <= 0;
        end
        else
        begin
            if (point_valid && !point_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("point with no expected point waiting");
                    errors++;
                end
                else
                begin
                    point_t ex;
                    ex = expected_points.pop_front();
                    if (out_x !== ex.x)
                    begin
                        $error("out_x expected %h actual %h", ex.x, out_x);
                        errors++;
                    end
                    if (out_y !== ex.y)
                    begin
                        $error("out_y expected %h actual %h", ex.y, out_y);
                        errors++;
                    end
                    if (out_z !== ex.z)
                    begin
                        $error("out_z expected %h actual %h", ex.z, out_z);
                        errors++;
                    end
                    if (degenerate !== ex.degen)
                    begin
                        $error("degenerate expected %b actual %b", ex.degen, degenerate);
                        errors++;
                    end
                end
            end
            if (stall_cnt > 0)
            begin
                stall_cnt <= stall_cnt - 1;
                point_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_cnt <= $urandom_range(0, 4);
                point_stall <= 1'b1;
            end
            else
                point_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((phase_valid && !phase_stall) || (point_valid && !point_stall) || cfg_we)
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        watchdog = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < 3; i++)
        begin
            cur_center[i] = 0;
            cur_ref[i] = 0;
        end
        cur_radius = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: zero reference, degenerate.
        add_phase(16'h0000);
        add_phase(16'hFFFF);

        set_circle(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                   32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0005_0000);
        add_phase(16'h0000);
        add_phase(16'h2000);
        add_phase(16'h4000);
        add_phase(16'h6000);
        add_phase(16'h8000);
        add_phase(16'hC000);
        add_phase(16'hFFFF);
        add_phase(16'h1001);

        // Center parallel to reference.
        set_circle(32'h0002_0000, 32'h0000_0000, 32'h0000_0000,
                   32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        add_phase(16'h1234);
        // Zero center.
        set_circle(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000);
        add_phase(16'h4321);
        // Zero radius with a valid basis.
        set_circle(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0);
        add_phase(16'h5555);
        // Saturation at the extremes.
        set_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
        add_phase(16'h0000);
        add_phase(16'h8000);
        add_phase(16'hAAAA);

        for (int ph = 0; ph < 14; ph++)
        begin
            set_circle(rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord(),
                       $urandom_range(0, 3) == 0 ? 32'h7FFF_FFFF : {1'b0, 31'($urandom)});
            if (ph == 13) quiet = 1'b1;
            queue_phases(75);
        end

        wait (pending_phases.size() == 0 && !in_xfer && expected_points.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_points.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/cpg_pkg.sv
rtl/cpg_queue.sv
rtl/cpg_front.sv
rtl/cpg_basis.sv
rtl/cpg_back.sv
rtl/circle_point_generator_3d_core.sv
rtl/cpg_checker.sv
tb/circle_point_generator_3d_core_tb.sv
